@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL.
// Both forms expect signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define TNB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property check failed");
// A condition that, once seen, must be followed by another in the next cycle.
`define TNB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TNB_ASSERT(lbl, prop)
`define TNB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/tnb_pkg.sv @@
package tnb_pkg;

  // Field widths.
  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;

  // Internal widths derived from the field widths.
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int LEN_BITS   = $clog2(CROSS_BITS + 1);
  localparam int MANT_BITS  = 30;
  localparam int SQ_BITS    = 2 * MANT_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int QUOT_BITS  = NORMAL_FRAC_BITS + 1;
  localparam int DVD_BITS   = MANT_BITS + NORMAL_FRAC_BITS + 1;

  localparam int QUEUE_DEPTH = 4;

  // One in Q1.NORMAL_FRAC_BITS.
  localparam logic signed [NORMAL_BITS-1:0] NORM_ONE =
    NORMAL_BITS'(1) <<< NORMAL_FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    coord_t                        box_min_x;
    coord_t                        box_min_y;
    coord_t                        box_min_z;
    coord_t                        box_max_x;
    coord_t                        box_max_y;
    coord_t                        box_max_z;
    logic                          degenerate;
  } tri_out_t;

  // Values that ride along the back pipeline unchanged.
  typedef struct packed {
    logic [2:0]                 neg;
    logic                       degen;
    logic [2:0][COORD_BITS-1:0] box_min;
    logic [2:0][COORD_BITS-1:0] box_max;
  } side_t;

  // One queue entry: cross product magnitudes plus side data.
  typedef struct packed {
    logic [2:0][CROSS_BITS-1:0] mag;
    side_t                      side;
  } qent_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Square root stage contents.
  typedef struct packed {
    logic [ROOT_BITS+1:0]      rem;
    logic [ROOT_BITS-1:0]      root;
    logic [SUM_BITS-1:0]       rad;
    logic [2:0][MANT_BITS-1:0] m;
    side_t                     side;
  } sq_t;

  // Divider stage contents, three lanes sharing one divisor.
  typedef struct packed {
    logic [ROOT_BITS-1:0]      len;
    logic [2:0][ROOT_BITS-1:0] rem;
    logic [2:0][QUOT_BITS-1:0] quo;
    logic [2:0][QUOT_BITS-1:0] low;
    side_t                     side;
  } dv_t;

endpackage

@@ hw/rtl/triangle_normal_and_box_setup.sv @@
// Channel | Direction | Payload   | Handshake
// in_     | input     | tri_in_t  | in_valid, in_stall
// out_    | output    | tri_out_t | out_valid, out_stall
//
// One triangle is taken and one result leaves per cycle unless the output
// stalls. A triangle passes four front stages, the queue, four normalizing
// stages, 31 square root stages, the divider stages and two output registers.
// The square root and divider stages, one bit each, set the depth.
// Reset (rst_n low at a clock edge) empties every stage and the queue.
// A stalled output holds the back part; the front fills the queue until full.
`include "assert_macros.svh"

module triangle_normal_and_box_setup import tnb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  tri_in_t  in_data,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output tri_out_t out_data
);

  logic     push, pop, adv, res_valid;
  qent_t    push_data, head;
  q_stat_t  q_stat;
  tri_out_t res;
  logic     out_valid_r;
  tri_out_t out_data_r;

  tnb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat)
  );

  tnb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  tnb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // The back part moves whenever the output register can take a request.
  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= res;
  end

  // A zero-area triangle leaves with a zero normal.
  `TNB_ASSERT(a_degen_zero, out_valid_r && out_data_r.degenerate |-> (out_data_r.normal_x == '0 && out_data_r.normal_y == '0 && out_data_r.normal_z == '0))
  // The box is never inverted.
  `TNB_ASSERT(a_box_order, out_valid_r |-> (out_data_r.box_min_x <= out_data_r.box_max_x && out_data_r.box_min_y <= out_data_r.box_max_y && out_data_r.box_min_z <= out_data_r.box_max_z))
  // Normal components stay within plus or minus one.
  `TNB_ASSERT(a_norm_range, out_valid_r |-> (out_data_r.normal_x <= NORM_ONE && out_data_r.normal_x >= -NORM_ONE && out_data_r.normal_y <= NORM_ONE && out_data_r.normal_y >= -NORM_ONE && out_data_r.normal_z <= NORM_ONE && out_data_r.normal_z >= -NORM_ONE))
  // A finished result waiting behind a full output register is not dropped.
  `TNB_ASSERT_NEXT(a_res_hold, res_valid && !adv, res_valid)

endmodule

@@ hw/rtl/tnb_front.sv @@
module tnb_front import tnb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  tri_in_t in_data,
  output logic    in_stall,
  output logic    push,
  output qent_t   push_data,
  input  q_stat_t q_stat
);

  logic fe;
  logic v1_r, v2_r, v3_r, v4_r;

  tri_in_t in_r;
  logic signed [DIFF_BITS-1:0] e1_r [3];
  logic signed [DIFF_BITS-1:0] e2_r [3];
  side_t s2_r, s3_r;
  logic signed [PROD_BITS-1:0] pl_r [3];
  logic signed [PROD_BITS-1:0] pr_r [3];
  qent_t ent_r;

  coord_t pa [3];
  coord_t pb [3];
  coord_t pc [3];
  logic signed [DIFF_BITS-1:0] e1 [3];
  logic signed [DIFF_BITS-1:0] e2 [3];
  side_t s2;
  logic signed [CROSS_BITS-1:0] n [3];
  qent_t ent;

  // The whole front moves unless its last stage cannot enter the queue.
  assign fe        = !(v4_r && q_stat.full);
  assign in_stall  = !fe;
  assign push      = v4_r && !q_stat.full;
  assign push_data = ent_r;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (fe) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Edge vectors and bounding box from the registered request.
  always_comb begin
    pa[0] = in_r.a_x; pa[1] = in_r.a_y; pa[2] = in_r.a_z;
    pb[0] = in_r.b_x; pb[1] = in_r.b_y; pb[2] = in_r.b_z;
    pc[0] = in_r.c_x; pc[1] = in_r.c_y; pc[2] = in_r.c_z;
    s2 = '0;
    for (int j = 0; j < 3; j++) begin
      e1[j] = DIFF_BITS'(pb[j]) - DIFF_BITS'(pa[j]);
      e2[j] = DIFF_BITS'(pc[j]) - DIFF_BITS'(pb[j]);
      s2.box_min[j] = pa[j];
      s2.box_max[j] = pa[j];
      if (pb[j] < $signed(s2.box_min[j])) s2.box_min[j] = pb[j];
      if (pc[j] < $signed(s2.box_min[j])) s2.box_min[j] = pc[j];
      if (pb[j] > $signed(s2.box_max[j])) s2.box_max[j] = pb[j];
      if (pc[j] > $signed(s2.box_max[j])) s2.box_max[j] = pc[j];
    end
  end

  // Cross product difference, sign split and zero check.
  always_comb begin
    ent            = '0;
    ent.side       = s3_r;
    for (int j = 0; j < 3; j++) begin
      n[j]           = CROSS_BITS'(pl_r[j]) - CROSS_BITS'(pr_r[j]);
      ent.side.neg[j] = n[j][CROSS_BITS-1];
      ent.mag[j]     = n[j][CROSS_BITS-1] ? CROSS_BITS'(-n[j]) : CROSS_BITS'(n[j]);
    end
    ent.side.degen = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  end

  // Front payload pipeline.
  always_ff @(posedge clk) begin
    if (fe) begin
      in_r <= in_data;
      for (int j = 0; j < 3; j++) begin
        e1_r[j] <= e1[j];
        e2_r[j] <= e2[j];
      end
      s2_r <= s2;
      pl_r[0] <= PROD_BITS'(e1_r[1]) * PROD_BITS'(e2_r[2]);
      pr_r[0] <= PROD_BITS'(e1_r[2]) * PROD_BITS'(e2_r[1]);
      pl_r[1] <= PROD_BITS'(e1_r[2]) * PROD_BITS'(e2_r[0]);
      pr_r[1] <= PROD_BITS'(e1_r[0]) * PROD_BITS'(e2_r[2]);
      pl_r[2] <= PROD_BITS'(e1_r[0]) * PROD_BITS'(e2_r[1]);
      pr_r[2] <= PROD_BITS'(e1_r[1]) * PROD_BITS'(e2_r[0]);
      s3_r <= s2_r;
      ent_r <= ent;
    end
  end

endmodule

@@ hw/rtl/tnb_queue.sv @@
module tnb_queue import tnb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qent_t   push_data,
  input  logic    pop,
  output qent_t   head,
  output q_stat_t q_stat
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  qent_t mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_BITS:0]   cnt_r;

  assign q_stat.full  = (cnt_r == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ hw/rtl/tnb_back.sv @@
module tnb_back import tnb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  qent_t    head,
  input  q_stat_t  q_stat,
  output logic     pop,
  output logic     res_valid,
  output tri_out_t res
);

  // One root bit per square root stage, one quotient bit per divider stage.
  function automatic sq_t sq_step(sq_t s);
    sq_t o;
    logic [ROOT_BITS+3:0] r2;
    logic [ROOT_BITS+3:0] t;
    o   = s;
    r2  = {s.rem, s.rad[SUM_BITS-1 -: 2]};
    t   = {2'b00, s.root, 2'b01};
    if (r2 >= t) begin
      o.rem  = (ROOT_BITS+2)'(r2 - t);
      o.root = {s.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      o.rem  = (ROOT_BITS+2)'(r2);
      o.root = {s.root[ROOT_BITS-2:0], 1'b0};
    end
    o.rad = s.rad << 2;
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t s);
    dv_t o;
    logic [ROOT_BITS:0] r2;
    o = s;
    for (int i = 0; i < 3; i++) begin
      r2 = {s.rem[i], s.low[i][QUOT_BITS-1]};
      if (r2 >= {1'b0, s.len}) begin
        o.rem[i] = ROOT_BITS'(r2 - {1'b0, s.len});
        o.quo[i] = {s.quo[i][QUOT_BITS-2:0], 1'b1};
      end else begin
        o.rem[i] = ROOT_BITS'(r2);
        o.quo[i] = {s.quo[i][QUOT_BITS-2:0], 1'b0};
      end
      o.low[i] = s.low[i] << 1;
    end
    return o;
  endfunction

  logic kv_r, mv_r, qv_r, sv_r, pv_r, fv_r;
  logic [2:0][CROSS_BITS-1:0] kmag_r;
  logic [LEN_BITS-1:0]        k_r;
  side_t                      kside_r, mside_r, qside_r;
  logic [2:0][MANT_BITS-1:0]  m_r, qm_r;
  logic [SQ_BITS-1:0]         sq_r [3];
  sq_t                        sqe_r;
  sq_t                        sqs_r [ROOT_BITS];
  logic [ROOT_BITS-1:0]       sqv_r;
  dv_t                        dve_r;
  dv_t                        dvs_r [QUOT_BITS];
  logic [QUOT_BITS-1:0]       dvv_r;
  tri_out_t                   res_r;

  logic [CROSS_BITS-1:0]           orv;
  logic [LEN_BITS-1:0]             kcalc;
  logic [CROSS_BITS+MANT_BITS-1:0] wide [3];
  sq_t                             sqin [ROOT_BITS+1];
  dv_t                             dvin [QUOT_BITS+1];
  logic [DVD_BITS-1:0]             dvd [3];
  dv_t                             dve;
  tri_out_t                        fin;
  logic [QUOT_BITS-1:0]            qs;

  assign pop       = adv && !q_stat.empty;
  assign res_valid = fv_r;
  assign res       = res_r;

  // Bit length of the largest magnitude equals that of their OR.
  always_comb begin
    orv   = head.mag[0] | head.mag[1] | head.mag[2];
    kcalc = '0;
    for (int i = 0; i < CROSS_BITS; i++) begin
      if (orv[i]) kcalc = LEN_BITS'(i + 1);
    end
  end

  // Common shift that puts the largest magnitude just under 2^MANT_BITS.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {kmag_r[i], {MANT_BITS{1'b0}}} >> k_r;
    end
  end

  // Chain inputs for the square root and divider stages.
  always_comb begin
    sqin[0] = sqe_r;
    for (int j = 0; j < ROOT_BITS; j++) sqin[j+1] = sqs_r[j];
    dvin[0] = dve_r;
    for (int j = 0; j < QUOT_BITS; j++) dvin[j+1] = dvs_r[j];
  end

  // Divider setup: rounding offset and the high part as the first remainder.
  always_comb begin
    dve      = '0;
    dve.len  = sqin[ROOT_BITS].root;
    dve.side = sqin[ROOT_BITS].side;
    for (int i = 0; i < 3; i++) begin
      dvd[i] = DVD_BITS'({sqin[ROOT_BITS].m[i], {NORMAL_FRAC_BITS{1'b0}}})
             + DVD_BITS'(sqin[ROOT_BITS].root >> 1);
      dve.rem[i] = ROOT_BITS'(dvd[i] >> QUOT_BITS);
      dve.low[i] = dvd[i][QUOT_BITS-1:0];
    end
  end

  // Saturation, sign and the zero-area repair.
  always_comb begin
    fin           = '0;
    fin.box_min_x = dvin[QUOT_BITS].side.box_min[0];
    fin.box_min_y = dvin[QUOT_BITS].side.box_min[1];
    fin.box_min_z = dvin[QUOT_BITS].side.box_min[2];
    fin.box_max_x = dvin[QUOT_BITS].side.box_max[0];
    fin.box_max_y = dvin[QUOT_BITS].side.box_max[1];
    fin.box_max_z = dvin[QUOT_BITS].side.box_max[2];
    fin.degenerate = dvin[QUOT_BITS].side.degen;
    for (int i = 0; i < 3; i++) begin
      qs = dvin[QUOT_BITS].quo[i];
      if (qs > QUOT_BITS'(NORM_ONE)) qs = QUOT_BITS'(NORM_ONE);
      if (dvin[QUOT_BITS].side.degen) qs = '0;
      case (i)
        0: fin.normal_x = dvin[QUOT_BITS].side.neg[i] ? -NORMAL_BITS'(qs) : NORMAL_BITS'(qs);
        1: fin.normal_y = dvin[QUOT_BITS].side.neg[i] ? -NORMAL_BITS'(qs) : NORMAL_BITS'(qs);
        default:
           fin.normal_z = dvin[QUOT_BITS].side.neg[i] ? -NORMAL_BITS'(qs) : NORMAL_BITS'(qs);
      endcase
    end
  end

  // Valid bits of the back stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r  <= 1'b0;
      mv_r  <= 1'b0;
      qv_r  <= 1'b0;
      sv_r  <= 1'b0;
      sqv_r <= '0;
      pv_r  <= 1'b0;
      dvv_r <= '0;
      fv_r  <= 1'b0;
    end else if (adv) begin
      kv_r  <= !q_stat.empty;
      mv_r  <= kv_r;
      qv_r  <= mv_r;
      sv_r  <= qv_r;
      sqv_r <= {sqv_r[ROOT_BITS-2:0], sv_r};
      pv_r  <= sqv_r[ROOT_BITS-1];
      dvv_r <= {dvv_r[QUOT_BITS-2:0], pv_r};
      fv_r  <= dvv_r[QUOT_BITS-1];
    end
  end

  // Normalize, square and sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      kmag_r  <= head.mag;
      k_r     <= kcalc;
      kside_r <= head.side;
      for (int i = 0; i < 3; i++) m_r[i] <= wide[i][MANT_BITS-1:0];
      mside_r <= kside_r;
      for (int i = 0; i < 3; i++) sq_r[i] <= SQ_BITS'(m_r[i]) * SQ_BITS'(m_r[i]);
      qm_r    <= m_r;
      qside_r <= mside_r;
      sqe_r.rem  <= '0;
      sqe_r.root <= '0;
      sqe_r.rad  <= SUM_BITS'(sq_r[0]) + SUM_BITS'(sq_r[1]) + SUM_BITS'(sq_r[2]);
      sqe_r.m    <= qm_r;
      sqe_r.side <= qside_r;
      dve_r <= dve;
      res_r <= fin;
    end
  end

  // Square root pipeline.
  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (adv) sqs_r[j] <= sq_step(sqin[j]);
    end
  end

  // Divider pipeline.
  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) dvs_r[j] <= dv_step(dvin[j]);
    end
  end

endmodule
